// File: hdl/i2cmbe_pkg.sv
// Shared types and constants of the I2C master bit engine.
`default_nettype none
package i2cmbe_pkg;

  localparam int unsigned CFG_W = 16;

  localparam logic CFG_DELAY_UNIT  = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [CFG_W-1:0] DELAY_UNIT_RST  = 16'd50;
  localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 16'd200;

  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_WRITE    = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;
  localparam logic [2:0] OP_WAIT_ACK = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_WAIT_ACK
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } q_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// File: hdl/i2cmbe_chan_if.sv
// Channel interfaces for input ticks and result words of the I2C master bit engine.
`default_nettype none
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source(output valid, output operation, output tx_byte, output send_ack,
                 output sda_in, input ready);
  modport sink(input valid, input operation, input tx_byte, input send_ack,
               input sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source(output valid, output scl_out, output sda_out, output busy_res,
                 output done_res, output rx_byte, output ack_missing, input ready);
  modport sink(input valid, input scl_out, input sda_out, input busy_res,
               input done_res, input rx_byte, input ack_missing, output ready);
endinterface
`default_nettype wire

// File: hdl/i2cmbe_front.sv
// Front end: accepts input words, decodes the operation and queues them for the engine.
`default_nettype none
module i2cmbe_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  i2cmbe_in_if.sink           in_i,
  output logic                q_valid_o,
  output i2cmbe_pkg::q_word_t q_word_o,
  input  wire                 q_pop_i
);

  localparam int unsigned PtrW = (i2cmbe_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(i2cmbe_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(i2cmbe_pkg::QUEUE_DEPTH + 1);

  i2cmbe_pkg::q_word_t entry_q [i2cmbe_pkg::QUEUE_DEPTH];
  i2cmbe_pkg::q_word_t word_in;
  i2cmbe_pkg::cmd_e    cmd;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  always_comb begin
    unique case (in_i.operation)
      i2cmbe_pkg::OP_START:    cmd = i2cmbe_pkg::CMD_START;
      i2cmbe_pkg::OP_STOP:     cmd = i2cmbe_pkg::CMD_STOP;
      i2cmbe_pkg::OP_WRITE:    cmd = i2cmbe_pkg::CMD_WRITE;
      i2cmbe_pkg::OP_READ:     cmd = i2cmbe_pkg::CMD_READ;
      i2cmbe_pkg::OP_WAIT_ACK: cmd = i2cmbe_pkg::CMD_WAIT_ACK;
      default:                 cmd = i2cmbe_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    word_in.cmd      = cmd;
    word_in.tx_byte  = in_i.tx_byte;
    word_in.send_ack = in_i.send_ack;
    word_in.sda_in   = in_i.sda_in;
  end

  assign in_i.ready = (count_q != CntW'(i2cmbe_pkg::QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_word_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(i2cmbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(i2cmbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= word_in;
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cmbe_back.sv
// Back end: runs the SCL/SDA phase sequencer one tick per queued word and registers the result.
`default_nettype none
module i2cmbe_back #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [i2cmbe_pkg::CFG_W-1:0]  delay_unit_i,
  input  wire [i2cmbe_pkg::CFG_W-1:0]  ack_timeout_i,
  input  wire                          q_valid_i,
  input  wire i2cmbe_pkg::q_word_t     q_word_i,
  output logic                         q_pop_o,
  output logic                         res_valid_o,
  output i2cmbe_pkg::res_t             res_o,
  input  wire                          res_ready_i
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_SP_A    = 4'd3;
  localparam logic [3:0] PH_SP_B    = 4'd4;
  localparam logic [3:0] PH_WR_A    = 4'd5;
  localparam logic [3:0] PH_WR_B    = 4'd6;
  localparam logic [3:0] PH_WR_C    = 4'd7;
  localparam logic [3:0] PH_RD_A    = 4'd8;
  localparam logic [3:0] PH_RD_B    = 4'd9;
  localparam logic [3:0] PH_AK_A    = 4'd10;
  localparam logic [3:0] PH_AK_B    = 4'd11;
  localparam logic [3:0] PH_WA_A    = 4'd12;
  localparam logic [3:0] PH_WA_B    = 4'd13;
  localparam logic [3:0] PH_WA_POLL = 4'd14;

  localparam logic [2:0] UNITS_LONG = 3'd4;
  localparam logic [2:0] UNITS_BIT  = 3'd2;
  localparam logic [2:0] UNITS_ONE  = 3'd1;
  localparam logic [3:0] BYTE_BITS  = 4'd8;

  localparam int unsigned CW = (DELAY_WIDTH > i2cmbe_pkg::CFG_W) ?
                               DELAY_WIDTH : i2cmbe_pkg::CFG_W;
  localparam logic [CW-1:0] MaxCnt = CW'({DELAY_WIDTH{1'b1}});

  logic [3:0]             phase_q, phase_d;
  logic [3:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic [DELAY_WIDTH-1:0] cnt_q, cnt_d, cnt_inc, unit;
  logic [2:0]             units_q, units_d, units_dec;
  logic [i2cmbe_pkg::CFG_W-1:0] poll_q, poll_d;
  logic                   scl_q, scl_d, sda_q, sda_d;
  logic [7:0]             rx_q, rx_d;
  logic                   ackf_q, ackf_d, ackc_q, ackc_d;
  logic                   done;
  logic                   step;
  logic [CW-1:0]          unit_ext;
  logic                   res_valid_q;
  i2cmbe_pkg::res_t       res_q;

  assign step    = q_valid_i && (!res_valid_q || res_ready_i);
  assign q_pop_o = step;

  assign unit_ext = CW'(delay_unit_i);
  always_comb begin
    if (unit_ext == '0) begin
      unit = DELAY_WIDTH'(1);
    end else if (unit_ext > MaxCnt) begin
      unit = '1;
    end else begin
      unit = unit_ext[DELAY_WIDTH-1:0];
    end
  end

  assign cnt_inc   = cnt_q + DELAY_WIDTH'(1);
  assign units_dec = (units_q != '0) ? units_q - 1'b1 : units_q;

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    units_d = units_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rx_d    = rx_q;
    ackf_d  = ackf_q;
    ackc_d  = ackc_q;
    done    = 1'b0;
    if (phase_q == PH_IDLE) begin
      cnt_d = '0;
      unique case (q_word_i.cmd)
        i2cmbe_pkg::CMD_START: begin
          scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_ST_A; units_d = UNITS_LONG;
        end
        i2cmbe_pkg::CMD_STOP: begin
          scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP_A; units_d = UNITS_LONG;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          shift_d = q_word_i.tx_byte; bit_d = '0; scl_d = 1'b0;
          sda_d = q_word_i.tx_byte[7]; phase_d = PH_WR_A; units_d = UNITS_BIT;
        end
        i2cmbe_pkg::CMD_READ: begin
          ackc_d = q_word_i.send_ack; bit_d = '0; shift_d = '0;
          sda_d = 1'b1; scl_d = 1'b0; phase_d = PH_RD_A; units_d = UNITS_BIT;
        end
        i2cmbe_pkg::CMD_WAIT_ACK: begin
          ackf_d = 1'b0; sda_d = 1'b1; phase_d = PH_WA_A; units_d = UNITS_ONE;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end else if (phase_q == PH_WA_POLL) begin
      if (!q_word_i.sda_in) begin
        scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
      end else if (poll_q >= ack_timeout_i) begin
        ackf_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
        phase_d = PH_SP_A; units_d = UNITS_LONG; cnt_d = '0;
      end else begin
        poll_d = poll_q + 1'b1;
      end
    end else if (cnt_inc < unit) begin
      cnt_d = cnt_inc;
    end else begin
      cnt_d   = '0;
      units_d = units_dec;
      if (units_dec == '0) begin
        unique case (phase_q)
          PH_ST_A: begin
            sda_d = 1'b0; phase_d = PH_ST_B; units_d = UNITS_LONG;
          end
          PH_ST_B: begin
            scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end
          PH_SP_A: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_SP_B; units_d = UNITS_LONG;
          end
          PH_SP_B: begin
            phase_d = PH_IDLE; done = 1'b1;
          end
          PH_WR_A: begin
            scl_d = 1'b1; phase_d = PH_WR_B; units_d = UNITS_BIT;
          end
          PH_WR_B: begin
            scl_d = 1'b0; phase_d = PH_WR_C; units_d = UNITS_BIT;
          end
          PH_WR_C: begin
            bit_d = bit_q + 1'b1;
            if (bit_d >= BYTE_BITS) begin
              phase_d = PH_IDLE; done = 1'b1;
            end else begin
              shift_d = {shift_q[6:0], 1'b0};
              sda_d   = shift_q[6];
              phase_d = PH_WR_A; units_d = UNITS_BIT;
            end
          end
          PH_RD_A: begin
            scl_d   = 1'b1;
            shift_d = {shift_q[6:0], q_word_i.sda_in};
            phase_d = PH_RD_B; units_d = UNITS_ONE;
          end
          PH_RD_B: begin
            bit_d = bit_q + 1'b1;
            scl_d = 1'b0;
            if (bit_d >= BYTE_BITS) begin
              rx_d    = shift_q;
              sda_d   = !ackc_q;
              phase_d = PH_AK_A; units_d = UNITS_BIT;
            end else begin
              phase_d = PH_RD_A; units_d = UNITS_BIT;
            end
          end
          PH_AK_A: begin
            scl_d = 1'b1; phase_d = PH_AK_B; units_d = UNITS_BIT;
          end
          PH_AK_B: begin
            scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end
          PH_WA_A: begin
            scl_d = 1'b1; phase_d = PH_WA_B; units_d = UNITS_ONE;
          end
          PH_WA_B: begin
            poll_d = '0; phase_d = PH_WA_POLL;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      cnt_q       <= '0;
      units_q     <= '0;
      poll_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_q        <= '0;
      ackf_q      <= 1'b0;
      ackc_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        cnt_q   <= cnt_d;
        units_q <= units_d;
        poll_q  <= poll_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        rx_q    <= rx_d;
        ackf_q  <= ackf_d;
        ackc_q  <= ackc_d;
      end
      if (step) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.scl         <= scl_d;
      res_q.sda         <= sda_d;
      res_q.busy        <= (phase_d != PH_IDLE);
      res_q.done        <= done;
      res_q.rx_byte     <= rx_d;
      res_q.ack_missing <= ackf_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// File: hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: configuration registers, front end and sequencer.
// Each accepted tick word yields one result word, registered at the edge it leaves the queue.
// With the output taken every cycle, one word is accepted every cycle; each passes the queue, then the result register.
// A two-word queue lets input and output stall independently; the sequencer does one tick a step.
// Reset: both lines released, sequencer idle, delay unit 50 ticks, acknowledge timeout 200 ticks.
`default_nettype none
module i2c_master_bit_engine #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  i2cmbe_in_if.sink                   in_i,
  i2cmbe_out_if.source                out_o,
  input  wire                         cfg_we_i,
  input  wire                         cfg_idx_i,
  input  wire [i2cmbe_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic [i2cmbe_pkg::CFG_W-1:0] delay_unit_q, ack_timeout_q;
  logic                         q_valid, q_pop, res_valid;
  i2cmbe_pkg::q_word_t          q_word;
  i2cmbe_pkg::res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_unit_q  <= i2cmbe_pkg::DELAY_UNIT_RST;
      ack_timeout_q <= i2cmbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cmbe_pkg::CFG_DELAY_UNIT:  delay_unit_q  <= cfg_wdata_i;
        i2cmbe_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  i2cmbe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_word_o  (q_word),
    .q_pop_i   (q_pop)
  );

  i2cmbe_back #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_unit_i  (delay_unit_q),
    .ack_timeout_i (ack_timeout_q),
    .q_valid_i     (q_valid),
    .q_word_i      (q_word),
    .q_pop_o       (q_pop),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (out_o.ready)
  );

  assign out_o.valid       = res_valid;
  assign out_o.scl_out     = res.scl;
  assign out_o.sda_out     = res.sda;
  assign out_o.busy_res    = res.busy;
  assign out_o.done_res    = res.done;
  assign out_o.rx_byte     = res.rx_byte;
  assign out_o.ack_missing = res.ack_missing;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.done_res && out_o.busy_res))
    else $error("A completed command is still reported busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("Input stalled while no result word is waiting.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !out_o.valid) |-> ##2 out_o.valid)
    else $error("Accepted word produced no result within two cycles.");

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the I2C master bit engine: random tick words against a line-level predictor.
`timescale 1ns / 100ps
module tb_top;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1000;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START_HI, SQ_START_LO, SQ_STOP_LO, SQ_STOP_HI,
    SQ_WR_SETUP, SQ_WR_HIGH, SQ_WR_LOW, SQ_RD_LOW, SQ_RD_HIGH,
    SQ_ACK_SETUP, SQ_ACK_HIGH, SQ_WA_RELEASE, SQ_WA_RISE, SQ_WA_POLL
  } seq_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = i2cmbe_pkg::CFG_DELAY_UNIT;
  logic [i2cmbe_pkg::CFG_W-1:0] cfg_wdata = '0;

  logic drv_valid = 1'b0;
  logic [2:0] drv_op = '0;
  logic [7:0] drv_tx = '0;
  logic drv_ack = 1'b0;
  logic drv_sda = 1'b1;
  logic take_ready = 1'b0;

  i2cmbe_in_if in_if ();
  i2cmbe_out_if out_if ();

  assign in_if.valid = drv_valid;
  assign in_if.operation = drv_op;
  assign in_if.tx_byte = drv_tx;
  assign in_if.send_ack = drv_ack;
  assign in_if.sda_in = drv_sda;
  assign out_if.ready = take_ready;

  i2c_master_bit_engine dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if),
    .out_o(out_if),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  i2cmbe_pkg::q_word_t tick_q[$];
  i2cmbe_pkg::res_t predicted_levels_q[$];
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  seq_e m_phase;
  logic [3:0] m_bit;
  logic [7:0] m_shift;
  logic [i2cmbe_pkg::CFG_W-1:0] m_count;
  logic [15:0] m_poll;
  logic m_scl;
  logic m_sda;
  logic [7:0] m_rx;
  logic m_missing;
  logic [2:0] m_units;
  logic m_ack_choice;
  logic [i2cmbe_pkg::CFG_W-1:0] m_unit_cfg;
  logic [i2cmbe_pkg::CFG_W-1:0] m_timeout_cfg;

  int n_items = 0;
  int n_issued = 0;
  int n_started = 0;
  int n_reads = 0;
  int n_acks = 0;
  int n_timeouts = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_settings = 0;

  task automatic reset_engine_model();
    m_phase = SQ_IDLE;
    m_bit = '0;
    m_shift = '0;
    m_count = '0;
    m_poll = '0;
    m_scl = 1'b1;
    m_sda = 1'b1;
    m_rx = '0;
    m_missing = 1'b0;
    m_units = '0;
    m_ack_choice = 1'b0;
    m_unit_cfg = i2cmbe_pkg::DELAY_UNIT_RST;
    m_timeout_cfg = i2cmbe_pkg::ACK_TIMEOUT_RST;
  endtask

  task automatic enter(input seq_e ph, input logic [2:0] units);
    m_phase = ph;
    m_units = units;
    m_count = '0;
  endtask

  function automatic logic unit_elapsed();
    logic [i2cmbe_pkg::CFG_W-1:0] unit;
    unit = (m_unit_cfg == '0) ? i2cmbe_pkg::CFG_W'(1) : m_unit_cfg;
    m_count = m_count + 1'b1;
    if (m_count >= unit) begin
      m_count = '0;
      if (m_units != 0) m_units = m_units - 1'b1;
      return m_units == 0;
    end
    return 1'b0;
  endfunction

  task automatic advance_bit_engine(input logic [2:0] op, input logic [7:0] tx,
                                    input logic ack, input logic sda);
    logic done;
    i2cmbe_pkg::res_t r;
    done = 1'b0;
    if (m_phase == SQ_IDLE) begin
      case (op)
        i2cmbe_pkg::CMD_START: begin
          m_scl = 1'b1;
          m_sda = 1'b1;
          enter(SQ_START_HI, 3'd4);
        end
        i2cmbe_pkg::CMD_STOP: begin
          m_scl = 1'b0;
          m_sda = 1'b0;
          enter(SQ_STOP_LO, 3'd4);
        end
        i2cmbe_pkg::CMD_WRITE: begin
          m_shift = tx;
          m_bit = '0;
          m_scl = 1'b0;
          m_sda = m_shift[7];
          enter(SQ_WR_SETUP, 3'd2);
        end
        i2cmbe_pkg::CMD_READ: begin
          m_ack_choice = ack;
          m_bit = '0;
          m_shift = '0;
          m_sda = 1'b1;
          m_scl = 1'b0;
          enter(SQ_RD_LOW, 3'd2);
          n_reads++;
        end
        i2cmbe_pkg::CMD_WAIT_ACK: begin
          m_missing = 1'b0;
          m_sda = 1'b1;
          enter(SQ_WA_RELEASE, 3'd1);
        end
        default: ;
      endcase
      if (m_phase != SQ_IDLE) n_started++;
    end else if (m_phase == SQ_WA_POLL) begin
      if (!sda) begin
        m_scl = 1'b0;
        m_phase = SQ_IDLE;
        done = 1'b1;
        n_acks++;
      end else if (m_poll >= m_timeout_cfg) begin
        m_missing = 1'b1;
        m_scl = 1'b0;
        m_sda = 1'b0;
        enter(SQ_STOP_LO, 3'd4);
        n_timeouts++;
      end else begin
        m_poll = m_poll + 1'b1;
      end
    end else if (unit_elapsed()) begin
      case (m_phase)
        SQ_START_HI: begin
          m_sda = 1'b0;
          enter(SQ_START_LO, 3'd4);
        end
        SQ_START_LO: begin
          m_scl = 1'b0;
          m_phase = SQ_IDLE;
          done = 1'b1;
        end
        SQ_STOP_LO: begin
          m_scl = 1'b1;
          m_sda = 1'b1;
          enter(SQ_STOP_HI, 3'd4);
        end
        SQ_STOP_HI: begin
          m_phase = SQ_IDLE;
          done = 1'b1;
        end
        SQ_WR_SETUP: begin
          m_scl = 1'b1;
          enter(SQ_WR_HIGH, 3'd2);
        end
        SQ_WR_HIGH: begin
          m_scl = 1'b0;
          enter(SQ_WR_LOW, 3'd2);
        end
        SQ_WR_LOW: begin
          m_bit = m_bit + 1'b1;
          if (m_bit >= 4'd8) begin
            m_phase = SQ_IDLE;
            done = 1'b1;
          end else begin
            m_shift = m_shift << 1;
            m_sda = m_shift[7];
            enter(SQ_WR_SETUP, 3'd2);
          end
        end
        SQ_RD_LOW: begin
          m_scl = 1'b1;
          m_shift = {m_shift[6:0], sda};
          enter(SQ_RD_HIGH, 3'd1);
        end
        SQ_RD_HIGH: begin
          m_bit = m_bit + 1'b1;
          m_scl = 1'b0;
          if (m_bit >= 4'd8) begin
            m_rx = m_shift;
            m_sda = !m_ack_choice;
            enter(SQ_ACK_SETUP, 3'd2);
          end else begin
            enter(SQ_RD_LOW, 3'd2);
          end
        end
        SQ_ACK_SETUP: begin
          m_scl = 1'b1;
          enter(SQ_ACK_HIGH, 3'd2);
        end
        SQ_ACK_HIGH: begin
          m_scl = 1'b0;
          m_phase = SQ_IDLE;
          done = 1'b1;
        end
        SQ_WA_RELEASE: begin
          m_scl = 1'b1;
          enter(SQ_WA_RISE, 3'd1);
        end
        SQ_WA_RISE: begin
          m_poll = '0;
          m_phase = SQ_WA_POLL;
        end
        default: m_phase = SQ_IDLE;
      endcase
    end
    r.scl = m_scl;
    r.sda = m_sda;
    r.busy = (m_phase != SQ_IDLE);
    r.done = done;
    r.rx_byte = m_rx;
    r.ack_missing = m_missing;
    predicted_levels_q.push_back(r);
  endtask

  int send_wait;
  bit send_armed;
  i2cmbe_pkg::q_word_t next_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      send_wait = 0;
      send_armed = 1'b0;
      reset_engine_model();
    end else begin
      if (drv_valid && in_if.ready) begin
        advance_bit_engine(drv_op, drv_tx, drv_ack, drv_sda);
      end
      if (!drv_valid || in_if.ready) begin
        if (!send_armed && tick_q.size() != 0) begin
          send_wait = gaps_on ? $urandom_range(0, 5) : 0;
          send_armed = 1'b1;
        end
        if (send_armed && send_wait == 0) begin
          next_word = tick_q.pop_front();
          drv_valid <= 1'b1;
          drv_op <= next_word.cmd;
          drv_tx <= next_word.tx_byte;
          drv_ack <= next_word.send_ack;
          drv_sda <= next_word.sda_in;
          send_armed = 1'b0;
        end else begin
          drv_valid <= 1'b0;
          if (send_armed) send_wait--;
        end
      end
    end
  end

  task automatic flag_field(input string name, input int want, input int got);
    if (want != got) begin
      if (n_mismatch < 10) begin
        $display("mismatch on word %0d: %s expected %0h, got %0h", n_checked, name, want, got);
      end
      n_mismatch++;
    end
  endtask

  task automatic check_levels();
    i2cmbe_pkg::res_t want;
    if (predicted_levels_q.size() == 0) begin
      if (n_mismatch < 10) $display("result word with no prediction pending");
      n_mismatch++;
    end else begin
      want = predicted_levels_q.pop_front();
      flag_field("scl_out", want.scl, out_if.scl_out);
      flag_field("sda_out", want.sda, out_if.sda_out);
      flag_field("busy_res", want.busy, out_if.busy_res);
      flag_field("done_res", want.done, out_if.done_res);
      flag_field("rx_byte", want.rx_byte, out_if.rx_byte);
      flag_field("ack_missing", want.ack_missing, out_if.ack_missing);
    end
    n_checked++;
  endtask

  int take_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_if.valid && take_ready) begin
        check_levels();
        take_wait = stalls_on ? $urandom_range(0, 5) : 0;
      end
      if (take_wait != 0) begin
        take_wait--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && in_if.ready) || (out_if.valid && take_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input logic sda);
    i2cmbe_pkg::q_word_t w;
    w.cmd = i2cmbe_pkg::cmd_e'(op);
    w.tx_byte = tx;
    w.send_ack = ack;
    w.sda_in = sda;
    tick_q.push_back(w);
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_q.size() != 0 || drv_valid || predicted_levels_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_timing(input logic [i2cmbe_pkg::CFG_W-1:0] unit,
                            input logic [i2cmbe_pkg::CFG_W-1:0] polls);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= i2cmbe_pkg::CFG_DELAY_UNIT;
    cfg_wdata <= unit;
    m_unit_cfg = unit;
    @(posedge clk_i);
    cfg_idx <= i2cmbe_pkg::CFG_ACK_TIMEOUT;
    cfg_wdata <= polls;
    m_timeout_cfg = polls;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Issues one command, then feeds SDA-sample ticks (some random ops if noisy) until the engine is idle.
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                         input int low_pct, input bit noisy);
    logic sda;
    push_tick(op, tx, ack, 1'($urandom_range(0, 1)));
    n_issued++;
    wait_drained();
    while (m_phase != SQ_IDLE) begin
      repeat (8) begin
        sda = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
        if (noisy && $urandom_range(0, 7) == 0) begin
          push_tick(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), sda);
        end else begin
          push_tick(i2cmbe_pkg::CMD_NONE, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), sda);
        end
      end
      wait_drained();
    end
  endtask

  task automatic run_transfer();
    int n_data;
    int k;
    run_cmd(i2cmbe_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            50, 1'b1);
    run_cmd(i2cmbe_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            50, 1'b1);
    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, ($urandom_range(0, 3) == 0) ? 0 : 25, 1'b1);
    n_data = $urandom_range(1, 2);
    for (k = 0; k < n_data; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        run_cmd(i2cmbe_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                50, 1'b1);
        run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0,
                ($urandom_range(0, 3) == 0) ? 0 : 25, 1'b1);
      end else begin
        run_cmd(i2cmbe_pkg::CMD_READ, 8'($urandom_range(0, 255)), k != n_data - 1, 50, 1'b1);
      end
    end
    run_cmd(i2cmbe_pkg::CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            50, 1'b1);
  endtask

  initial begin : stimulus
    int target;
    logic [i2cmbe_pkg::CFG_W-1:0] unit;
    logic [i2cmbe_pkg::CFG_W-1:0] polls;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 25, 1'b0);

    set_timing(16'd1, 16'd3);
    run_cmd(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WRITE, 8'h00, 1'b0, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 25, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WRITE, 8'hFF, 1'b1, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WRITE, 8'hA5, 1'b0, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_READ, 8'h00, 1'b1, 0, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_READ, 8'hFF, 1'b0, 100, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_NONE, 8'hFF, 1'b1, 50, 1'b0);
    run_cmd(OP_SPARE_A, 8'h5A, 1'b1, 50, 1'b0);
    run_cmd(OP_SPARE_B, 8'hC3, 1'b0, 50, 1'b0);
    push_tick(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
    run_cmd(i2cmbe_pkg::CMD_WRITE, 8'h3C, 1'b1, 50, 1'b0);

    set_timing(16'd0, 16'd0);
    run_cmd(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 50, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 100, 1'b0);

    set_timing(16'd2, 16'd5);
    run_cmd(i2cmbe_pkg::CMD_READ, 8'h00, 1'b1, 50, 1'b0);

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_timing(16'd1, 16'hFFFF);
    run_cmd(i2cmbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 25, 1'b0);

    while (n_items < ITEM_TARGET) begin
      unit = i2cmbe_pkg::CFG_W'($urandom_range(0, 2));
      polls = i2cmbe_pkg::CFG_W'($urandom_range(0, 6));
      set_timing(unit, polls);
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      target = n_items + 120;
      while (n_items < target && n_items < ITEM_TARGET) begin
        if ($urandom_range(0, 3) != 0) begin
          run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 50, 1'b1);
        end else begin
          run_transfer();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("sent %0d tick words and checked %0d result words over %0d timing settings",
             n_items, n_checked, n_settings);
    $display("%0d commands started, %0d reads, %0d acks, %0d timeouts, %0d field mismatches",
             n_started, n_reads, n_acks, n_timeouts, n_mismatch);
    if (n_mismatch == 0 && predicted_levels_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_chan_if.sv
hdl/i2cmbe_front.sv
hdl/i2cmbe_back.sv
hdl/i2c_master_bit_engine.sv
test/tb_top.sv
